FILE: rtl/core/amb_pkg.sv
// ============================================================================
// amb_pkg
// Shared types, constants and fixed-point helpers of the model matrix builder.
// ============================================================================
`default_nettype none

package amb_pkg;

    localparam int ANG_W        = 16;             // input angle, Q3.12
    localparam int FIX_W        = 32;             // Q16.16 values
    localparam int RA_W         = 33;             // reduced angle, Q30 in [-pi, pi]
    localparam int Q_W          = 34;             // Q30 working values
    localparam int PROD_W       = FIX_W + Q_W;    // Q16 x Q30 product
    localparam int ACC_W        = 2 * Q_W;        // wide accumulator / Q30 product
    localparam int CORDIC_STEPS = 24;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic signed [Q_W-1:0]   q30_t;
    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic signed [RA_W-1:0]  rang_t;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam q30_t               CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [ACC_W-1:0] ROUND30 = ACC_W'(64'sd536870912);
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(-64'sd2147483648);

    localparam fix_t ONE_Q16 = 32'sd65536;

    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // queue entry: reduced angles plus the untouched translation and scale
    typedef struct packed {
        rang_t ang_x;
        rang_t ang_y;
        rang_t ang_z;
        fix_t  shift_x;
        fix_t  shift_y;
        fix_t  shift_z;
        fix_t  scale;
    } amb_item_t;

    typedef struct packed {
        fix_t tx;
        fix_t ty;
        fix_t tz;
        fix_t k;
    } amb_tk_t;

    // Q30 x Q30 rounded back to Q30
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [ACC_W-1:0] prod;
        prod = a * b;
        prod = prod + ROUND30;
        return q30_t'(prod >>> 30);
    endfunction

    // round a Q46 sum to Q16 and clamp to 32 bits
    function automatic fix_t sat_out(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        v = (acc + ROUND30) >>> 30;
        if (v > SAT_HI)
            return fix_t'(SAT_HI);
        else if (v < SAT_LO)
            return fix_t'(SAT_LO);
        else
            return fix_t'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/amb_front.sv
// ============================================================================
// amb_front
// Input side: takes items, wraps the angles into [-pi, pi] and queues them.
// ============================================================================
`default_nettype none

module amb_front
    import amb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [ANG_W-1:0] angle_x,
    input  wire logic signed [ANG_W-1:0] angle_y,
    input  wire logic signed [ANG_W-1:0] angle_z,
    input  wire fix_t                    shift_x,
    input  wire fix_t                    shift_y,
    input  wire fix_t                    shift_z,
    input  wire fix_t                    scale_factor,
    output logic                         q_valid,
    output amb_item_t                    q_item,
    input  wire logic                    q_pop
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    amb_item_t        mem_reg [QUEUE_DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;
    amb_item_t        item_in;

    // the input spans at most 8 rad, so one wrap by 2pi always lands in range
    function automatic rang_t reduce(input logic signed [ANG_W-1:0] ang);
        logic signed [35:0] a;
        a = {{(36 - ANG_W - 18){ang[ANG_W-1]}}, ang, 18'd0};
        if (a > Q30_PI)
            a = a - Q30_TWO_PI;
        else if (a < -Q30_PI)
            a = a + Q30_TWO_PI;
        return a[RA_W-1:0];
    endfunction

    assign in_stall = (count_reg == CW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        item_in.ang_x   = reduce(angle_x);
        item_in.ang_y   = reduce(angle_y);
        item_in.ang_z   = reduce(angle_z);
        item_in.shift_x = shift_x;
        item_in.shift_y = shift_y;
        item_in.shift_z = shift_z;
        item_in.scale   = scale_factor;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

FILE: rtl/core/amb_cordic.sv
// ============================================================================
// amb_cordic
// One sine/cosine lane: quadrant fold then a pipelined rotation-mode CORDIC.
// ============================================================================
`default_nettype none

module amb_cordic
    import amb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire rang_t ang,
    output q30_t       sin_val,
    output q30_t       cos_val
);

    q30_t x_reg   [CORDIC_STEPS+1];
    q30_t y_reg   [CORDIC_STEPS+1];
    q30_t z_reg   [CORDIC_STEPS+1];
    logic neg_reg [CORDIC_STEPS+1];

    logic signed [35:0] a_wide;
    q30_t               z0_next;
    logic               neg0_next;

    // fold into [-pi/2, pi/2]; either fold flips the cosine
    always_comb
    begin
        a_wide    = 36'(ang);
        z0_next   = q30_t'(a_wide);
        neg0_next = 1'b0;
        if (a_wide > Q30_HALF_PI)
        begin
            z0_next   = q30_t'(Q30_PI - a_wide);
            neg0_next = 1'b1;
        end
        else if (a_wide < -Q30_HALF_PI)
        begin
            z0_next   = q30_t'(-Q30_PI - a_wide);
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z0_next;
            neg_reg[0] <= neg0_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        q30_t xs, ys, at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = q30_t'({2'b00, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign sin_val = y_reg[CORDIC_STEPS];
    assign cos_val = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/amb_back.sv
// ============================================================================
// amb_back
// Execution side: trig lanes, rotation products, then one matrix row a cycle when the output is not stalled.
// ============================================================================
`default_nettype none

module amb_back
    import amb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire amb_item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic [1:0]     row_index,
    output fix_t           entry_c0,
    output fix_t           entry_c1,
    output fix_t           entry_c2,
    output fix_t           entry_c3,
    output logic           last_row
);

    localparam int LAT = CORDIC_STEPS + 1;

    logic adv, issue, prod_free, out_free;

    // trig lanes and the side pipe that keeps translation and scale aligned
    q30_t    sx_c, cx_c, sy_c, cy_c, sz_c, cz_c;
    logic    v_reg  [LAT];
    amb_tk_t tk_reg [LAT];

    // sine/cosine stage
    logic    tv_reg;
    q30_t    sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    amb_tk_t tk_t_reg;

    // first products
    logic    p1v_reg;
    q30_t    cycz_reg, cysz_reg, sxsy_reg, cxsy_reg, cxsz_reg;
    q30_t    cxcz_reg, sxsz_reg, sxcz_reg, sxcy_reg, cxcy_reg;
    q30_t    sy1_reg, sz1_reg, cz1_reg;
    amb_tk_t tk1_reg;

    // rotation matrix, held until its rows are issued
    logic    p2v_reg;
    q30_t    r_reg [3][3];
    amb_tk_t tk2_reg;
    q30_t    q_neg;

    // row stage
    logic [1:0]              row_reg;
    q30_t                    rsel [3];
    logic                    prod_valid_reg, prod_valid_next;
    logic [1:0]              prod_row_reg;
    logic signed [PROD_W-1:0] kr_reg [3];
    logic signed [PROD_W-1:0] rt_reg [3];
    logic signed [ACC_W-1:0] rt_sum;

    logic out_valid_reg, out_valid_next;

    assign out_free  = !out_valid_reg || !out_stall;
    assign prod_free = !prod_valid_reg || out_free;
    assign issue     = p2v_reg && prod_free;
    assign adv       = !p2v_reg || (issue && row_reg == ROW_LAST);
    assign q_pop     = adv && q_valid;

    amb_cordic u_lane_x (.clk(clk), .en(adv), .ang(q_item.ang_x), .sin_val(sx_c), .cos_val(cx_c));
    amb_cordic u_lane_y (.clk(clk), .en(adv), .ang(q_item.ang_y), .sin_val(sy_c), .cos_val(cy_c));
    amb_cordic u_lane_z (.clk(clk), .en(adv), .ang(q_item.ang_z), .sin_val(sz_c), .cos_val(cz_c));

    // ---------------- pipeline valid flags and row counter ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
            tv_reg         <= 1'b0;
            p1v_reg        <= 1'b0;
            p2v_reg        <= 1'b0;
            row_reg        <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v_reg[0] <= q_valid;
                for (int i = 1; i < LAT; i++)
                    v_reg[i] <= v_reg[i-1];
                tv_reg  <= v_reg[LAT-1];
                p1v_reg <= tv_reg;
                p2v_reg <= p1v_reg;
            end
            if (issue)
                row_reg <= row_reg + 1'b1;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (issue)
            prod_valid_next = 1'b1;
        else if (out_free)
            prod_valid_next = 1'b0;
        out_valid_next = out_free ? prod_valid_reg : out_valid_reg;
    end

    // ---------------- trig and rotation product pipe ----------------
    assign q_neg = -cxsy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tk_reg[0] <= '{tx: q_item.shift_x, ty: q_item.shift_y,
                           tz: q_item.shift_z, k: q_item.scale};
            for (int i = 1; i < LAT; i++)
                tk_reg[i] <= tk_reg[i-1];

            sx_reg   <= sx_c;
            cx_reg   <= cx_c;
            sy_reg   <= sy_c;
            cy_reg   <= cy_c;
            sz_reg   <= sz_c;
            cz_reg   <= cz_c;
            tk_t_reg <= tk_reg[LAT-1];

            cycz_reg <= mul30(cy_reg, cz_reg);
            cysz_reg <= mul30(cy_reg, sz_reg);
            sxsy_reg <= mul30(sx_reg, sy_reg);
            cxsy_reg <= mul30(cx_reg, sy_reg);
            cxsz_reg <= mul30(cx_reg, sz_reg);
            cxcz_reg <= mul30(cx_reg, cz_reg);
            sxsz_reg <= mul30(sx_reg, sz_reg);
            sxcz_reg <= mul30(sx_reg, cz_reg);
            sxcy_reg <= mul30(sx_reg, cy_reg);
            cxcy_reg <= mul30(cx_reg, cy_reg);
            sy1_reg  <= sy_reg;
            sz1_reg  <= sz_reg;
            cz1_reg  <= cz_reg;
            tk1_reg  <= tk_t_reg;

            r_reg[0][0] <= cycz_reg;
            r_reg[0][1] <= -cysz_reg;
            r_reg[0][2] <= sy1_reg;
            r_reg[1][0] <= mul30(sxsy_reg, cz1_reg) + cxsz_reg;
            r_reg[1][1] <= -mul30(sxsy_reg, sz1_reg) + cxcz_reg;
            r_reg[1][2] <= -sxcy_reg;
            r_reg[2][0] <= mul30(q_neg, cz1_reg) + sxsz_reg;
            r_reg[2][1] <= -mul30(q_neg, sz1_reg) + sxcz_reg;
            r_reg[2][2] <= cxcy_reg;
            tk2_reg     <= tk1_reg;
        end
    end

    // ---------------- row products ----------------
    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                rsel[0] = r_reg[0][0];
                rsel[1] = r_reg[0][1];
                rsel[2] = r_reg[0][2];
            end
            2'd1:
            begin
                rsel[0] = r_reg[1][0];
                rsel[1] = r_reg[1][1];
                rsel[2] = r_reg[1][2];
            end
            2'd2:
            begin
                rsel[0] = r_reg[2][0];
                rsel[1] = r_reg[2][1];
                rsel[2] = r_reg[2][2];
            end
            default:
            begin
                rsel[0] = '0;
                rsel[1] = '0;
                rsel[2] = '0;
            end
        endcase
    end

    assign rt_sum = ACC_W'(rt_reg[0]) + ACC_W'(rt_reg[1]) + ACC_W'(rt_reg[2]);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_row_reg <= row_reg;
            kr_reg[0]    <= tk2_reg.k * rsel[0];
            kr_reg[1]    <= tk2_reg.k * rsel[1];
            kr_reg[2]    <= tk2_reg.k * rsel[2];
            rt_reg[0]    <= rsel[0] * tk2_reg.tx;
            rt_reg[1]    <= rsel[1] * tk2_reg.ty;
            rt_reg[2]    <= rsel[2] * tk2_reg.tz;
        end
        if (prod_valid_reg && out_free)
        begin
            row_index <= prod_row_reg;
            if (prod_row_reg == ROW_LAST)
            begin
                entry_c0 <= '0;
                entry_c1 <= '0;
                entry_c2 <= '0;
                entry_c3 <= ONE_Q16;
                last_row <= 1'b1;
            end
            else
            begin
                entry_c0 <= sat_out(ACC_W'(kr_reg[0]));
                entry_c1 <= sat_out(ACC_W'(kr_reg[1]));
                entry_c2 <= sat_out(ACC_W'(kr_reg[2]));
                entry_c3 <= sat_out(rt_sum);
                last_row <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- checks ----------------
    a_last_is_row3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_row |-> row_index == ROW_LAST)
        else $error("last_row flagged on a row other than the bottom row");

    a_prod_moves: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && out_free |=> out_valid)
        else $error("row product lost on its way to the output register");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        issue && row_reg == ROW_LAST |=> row_reg == 2'd0 && !p2v_reg || row_reg == 2'd0)
        else $error("row counter failed to wrap after the bottom row");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_row
        |=> !out_valid || row_index == 2'($past(row_index) + 2'd1))
        else $error("rows left out of order");

    a_no_adv_mid_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        p2v_reg && row_reg != ROW_LAST |-> !adv)
        else $error("matrix replaced before all its rows were issued");

endmodule

`default_nettype wire

FILE: rtl/core/affine_model_matrix_builder.sv
// An accepted item runs through the CORDIC lanes and the sine/cosine, product,
// matrix, row product and output registers before its first row appears.
// The pipe holds while a matrix issues its rows; the row stage sends one row per
// cycle when not stalled, through its shared set of six output multipliers.
// Reset clears the input queue, all pipeline valid flags and the row counter.
// ============================================================================
// affine_model_matrix_builder
// Builds the 4x4 Euler XYZ rotation, translation and scale matrix, row by row.
// ============================================================================
`default_nettype none

module affine_model_matrix_builder
    import amb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [ANG_W-1:0] angle_x,
    input  wire logic signed [ANG_W-1:0] angle_y,
    input  wire logic signed [ANG_W-1:0] angle_z,
    input  wire fix_t                    shift_x,
    input  wire fix_t                    shift_y,
    input  wire fix_t                    shift_z,
    input  wire fix_t                    scale_factor,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   row_index,
    output fix_t                         entry_c0,
    output fix_t                         entry_c1,
    output fix_t                         entry_c2,
    output fix_t                         entry_c3,
    output logic                         last_row
);

    logic      q_valid, q_pop;
    amb_item_t q_item;

    amb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .angle_x      (angle_x),
        .angle_y      (angle_y),
        .angle_z      (angle_z),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .shift_z      (shift_z),
        .scale_factor (scale_factor),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    amb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_index (row_index),
        .entry_c0  (entry_c0),
        .entry_c1  (entry_c1),
        .entry_c2  (entry_c2),
        .entry_c3  (entry_c3),
        .last_row  (last_row)
    );

endmodule

`default_nettype wire

FILE: tb/sv/amb_checker.sv
// ============================================================================
// amb_checker
// Watches both channels of the model matrix builder, predicts the four rows of
// every accepted item with its own fixed-point model and compares field by field.
// ============================================================================
`default_nettype none

module amb_checker
    import amb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic signed [ANG_W-1:0] angle_x,
    input  wire logic signed [ANG_W-1:0] angle_y,
    input  wire logic signed [ANG_W-1:0] angle_z,
    input  wire fix_t                    shift_x,
    input  wire fix_t                    shift_y,
    input  wire fix_t                    shift_z,
    input  wire fix_t                    scale_factor,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic [1:0]              row_index,
    input  wire fix_t                    entry_c0,
    input  wire fix_t                    entry_c1,
    input  wire fix_t                    entry_c2,
    input  wire fix_t                    entry_c3,
    input  wire logic                    last_row,
    output int                           errors,
    output int                           pending,
    output int                           rows_seen
);

    typedef struct packed {
        logic [1:0] row;
        fix_t       c0;
        fix_t       c1;
        fix_t       c2;
        fix_t       c3;
        logic       last;
    } mat_row_t;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint HALF_LSB    = 64'sd536870912;

    mat_row_t row_queue[$];

    function automatic longint rnd30(input longint a, input longint b);
        return (a * b + HALF_LSB) >>> 30;
    endfunction

    function automatic fix_t clamp_q16(input longint acc);
        longint v;
        v = (acc + HALF_LSB) >>> 30;
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return fix_t'(v);
    endfunction

    task automatic sine_cosine(input logic signed [15:0] ang, output longint s,
                               output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit flip;
        a = longint'(ang) * 262144;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        for (int n = 0; n < 2; n++)
        begin
            if (a > PI_Q30)
                a -= TWO_PI_Q30;
            else if (a < -PI_Q30)
                a += TWO_PI_Q30;
        end
        // fold into the right half-plane, cosine changes sign
        if (a > HALF_PI_Q30)
        begin
            a = PI_Q30 - a;
            flip = 1;
        end
        else if (a < -HALF_PI_Q30)
        begin
            a = -PI_Q30 - a;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        s = y;
        c = flip ? -x : x;
    endtask

    task automatic predict_matrix();
        longint sx, cx, sy, cy, sz, cz, p, q, acc;
        longint r[3][3];
        longint t[3];
        longint k;
        mat_row_t e;
        sine_cosine(angle_x, sx, cx);
        sine_cosine(angle_y, sy, cy);
        sine_cosine(angle_z, sz, cz);
        t[0] = shift_x;
        t[1] = shift_y;
        t[2] = shift_z;
        k = scale_factor;
        r[0][0] = rnd30(cy, cz);
        r[0][1] = -rnd30(cy, sz);
        r[0][2] = sy;
        p = rnd30(sx, sy);
        r[1][0] = rnd30(p, cz) + rnd30(cx, sz);
        r[1][1] = -rnd30(p, sz) + rnd30(cx, cz);
        r[1][2] = -rnd30(sx, cy);
        q = -rnd30(cx, sy);
        r[2][0] = rnd30(q, cz) + rnd30(sx, sz);
        r[2][1] = -rnd30(q, sz) + rnd30(sx, cz);
        r[2][2] = rnd30(cx, cy);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += r[i][j] * t[j];
            e.row  = 2'(i);
            e.c0   = clamp_q16(k * r[i][0]);
            e.c1   = clamp_q16(k * r[i][1]);
            e.c2   = clamp_q16(k * r[i][2]);
            e.c3   = clamp_q16(acc);
            e.last = 1'b0;
            row_queue.push_back(e);
        end
        e = '{row: ROW_LAST, c0: '0, c1: '0, c2: '0, c3: ONE_Q16, last: 1'b1};
        row_queue.push_back(e);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch: %s got %0d want %0d (row %0d)", what, got, want, row_index);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            rows_seen <= 0;
            row_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                rows_seen <= rows_seen + 1;
                if (row_queue.size() == 0)
                    report("unexpected row", 1, 0);
                else
                begin
                    mat_row_t w;
                    w = row_queue.pop_front();
                    if (row_index !== w.row)
                        report("row_index", row_index, w.row);
                    if (entry_c0 !== w.c0)
                        report("entry_c0", entry_c0, w.c0);
                    if (entry_c1 !== w.c1)
                        report("entry_c1", entry_c1, w.c1);
                    if (entry_c2 !== w.c2)
                        report("entry_c2", entry_c2, w.c2);
                    if (entry_c3 !== w.c3)
                        report("entry_c3", entry_c3, w.c3);
                    if (last_row !== w.last)
                        report("last_row", last_row, w.last);
                end
            end
            if (in_valid && !in_stall)
                predict_matrix();
        end
    end

    assign pending = row_queue.size();

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ============================================================================
// tb
// Drives transform items into the model matrix builder with random gaps and
// output stalls, including one long hold-off; the checker does the comparing.
// ============================================================================
`default_nettype none

module tb
    import amb_pkg::*;
();

    localparam int N_RANDOM = 110;
    localparam int LIMIT    = 200000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [ANG_W-1:0] angle_x = '0;
    logic signed [ANG_W-1:0] angle_y = '0;
    logic signed [ANG_W-1:0] angle_z = '0;
    fix_t                    shift_x = '0;
    fix_t                    shift_y = '0;
    fix_t                    shift_z = '0;
    fix_t                    scale_factor = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              row_index;
    fix_t                    entry_c0, entry_c1, entry_c2, entry_c3;
    logic                    last_row;
    int                      errors, pending, rows_seen;
    int                      cycles = 0;
    int                      items_sent = 0;
    bit                      hold_off = 1'b0;
    bit                      long_hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    affine_model_matrix_builder u_dut (.*);

    amb_checker u_chk (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd6434;   // near pi/2
            3: return -16'sd12868; // near -pi
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic fix_t pick_fix();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00010000;
            3: return 32'($urandom_range(0, 32'h0004ffff)) - 32'sh00028000;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input fix_t tx,
                             input fix_t ty, input fix_t tz, input fix_t k);
        in_valid     <= 1'b1;
        angle_x      <= ax;
        angle_y      <= ay;
        angle_z      <= az;
        shift_x      <= tx;
        shift_y      <= ty;
        shift_z      <= tz;
        scale_factor <= k;
        // hold until the block takes the item
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // receiver: random stalls, plus one long hold-off while the sender keeps going
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (cycles % 200 < 40)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        wait (items_sent == 30);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        long_hold_done = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, extremes of every field, wraps and folds
        send_item(0, 0, 0, 0, 0, 0, 32'sh00010000);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff);
        send_item(16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000);
        send_item(16'sd6434, -16'sd6434, 16'sd12868, 32'sh00010000, -32'sh00010000,
                  32'sh7fffffff, 32'sh80000000);
        send_item(-16'sd12868, 16'sd6500, -16'sd6500, 32'sh80000000, 32'sh7fffffff,
                  0, 32'sh7fffffff);
        send_item(16'sd25736, -16'sd25736, 16'sd30000, 32'sh12345678, 32'shedcba987,
                  32'sh0, 32'shffff0000);
        send_item(16'sh5555, 16'shaaaa, 16'sh0001, 32'sh55555555, 32'shaaaaaaaa,
                  32'sh00000001, 32'shffffffff);
        send_item(16'shffff, 16'sh0100, 16'sh3243, 32'sh00000000, 32'sh00000001,
                  32'shffffffff, 32'sh00000000);
        idle_gap(1);

        repeat (N_RANDOM)
        begin
            send_item(pick_angle(), pick_angle(), pick_angle(), pick_fix(), pick_fix(),
                      pick_fix(), pick_fix());
            idle_gap(gap_len());
        end
        in_valid <= 1'b0;

        wait (long_hold_done && pending == 0);
        repeat (60) @(posedge clk);
        $display("covered %0d transforms, %0d rows, incl. one long output hold-off",
                 items_sent, rows_seen);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
